### rtl/core/dqvm_pkg.sv
// Shared constants, state encoding and control word of the dual quad VCA mixer.
package dqvm_pkg;

    // Channel grouping: channels below the group size belong to group 0.
    localparam int CHANNELS_PER_GROUP = 4;
    localparam logic [4:0] G0_LAST  = 5'(CHANNELS_PER_GROUP - 1);
    localparam logic [4:0] G1_FIRST = 5'(CHANNELS_PER_GROUP);
    localparam logic [4:0] G1_LAST  = 5'(2 * CHANNELS_PER_GROUP - 1);

    // Default number of segments in the exponential gain curve.
    localparam int EXP_POINTS_DEFAULT = 64;

    // Gain and curve entries are Q1.14 magnitudes, 0 to 16384.
    localparam int ONE_Q14 = 16384;
    localparam int ENTRY_W = 15;
    localparam int FRAC_W  = 14;

    // Serial multiplier: 18-bit multiplicand, 15 multiplier bits, rounded by 2^-14.
    localparam int MUL_BITS = 15;
    localparam int MCAND_W  = 18;
    localparam int PROD_W   = MCAND_W + MUL_BITS;
    localparam int MRES_W   = PROD_W - FRAC_W;

    // Serial divide by five of the scaled CV magnitude.
    localparam int DIVIDEND_W = 19;
    localparam int QUOT_W     = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXP_MODE = 2'd0;
    localparam logic [1:0] CFG_WORMHOLE = 2'd1;
    localparam logic [1:0] CFG_CV_RANGE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_GAIN,
        ST_CRV_IDX,
        ST_CRV_RD,
        ST_CRV_GO,
        ST_CRV_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic gain_load;
        logic rom_load;
        logic mul_start;
        logic mul_sel_curve;
        logic curve_take;
        logic prod_take;
        logic out_load;
    } ctrl_t;

endpackage

### rtl/core/dual_quad_vca_mixer_core.sv
// Top level of the dual quad VCA mixer: sequencer, gain, source select and group sums.
//
// Channel words (channel, audio, knob, CV and jack flags) enter on the in_valid/in_stall
// channel, in channel order: 0 to 3 form group 0 and 4 to 7 form group 1. Each accepted
// word yields one result word on out_valid/out_stall: the channel, gain times input,
// and on a group's last channel the group sum clamped to +-10 V (mix_valid set).
// Configuration (curve enable, wormhole, CV range) is written on cfg_valid/cfg_ready,
// which is always ready; write it only while no channel word is in flight.
// One word at a time is processed. The CV scaling goes through a bit-serial divide by
// five and the product gain*input through a bit-serial multiplier (15 steps plus a
// rounding step). Without the curve the sequencer runs divide, gain load, multiply and
// done; with the curve the table lookup and a second pass through the shared multiplier
// come between the gain load and the multiply. A new word is taken only once the
// result has been loaded into the output register.
// The result sits in an output register; a new word is accepted while it waits, and
// the sequencer holds its next result until the receiver stops stalling.
// Reset clears the group sums, the wormhole value and the output valid, and loads the
// configuration defaults (curve off, wormhole on, both CV ranges at 0.1 per volt).
module dual_quad_vca_mixer_core #(
    parameter int EXP_TABLE_POINTS = dqvm_pkg::EXP_POINTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         channel,
    input  logic signed [15:0] audio_sample,
    input  logic               audio_connected,
    input  logic signed [15:0] level_knob,
    input  logic signed [15:0] cv_sample,
    input  logic               cv_connected,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         out_channel,
    output logic signed [17:0] channel_out,
    output logic               mix_valid,
    output logic signed [15:0] mix_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_data
);
    import dqvm_pkg::*;

    localparam logic signed [17:0] TEN_VOLTS = 18'sd20480;
    localparam logic signed [17:0] GAIN_MAX  = 18'(ONE_Q14);
    localparam logic signed [17:0] GAIN_MIN  = -18'(ONE_Q14);
    localparam logic signed [19:0] SUM0_MAX  = 20'sd131071;
    localparam logic signed [19:0] SUM0_MIN  = -20'sd131072;
    localparam logic signed [20:0] SUM1_MAX  = 21'sd524287;
    localparam logic signed [20:0] SUM1_MIN  = -21'sd524288;
    localparam logic signed [19:0] MIX_MAX   = 20'sd20480;
    localparam logic signed [19:0] MIX_MIN   = -20'sd20480;

    // Configuration registers.
    logic [1:0] exp_mode_reg;
    logic       wormhole_reg;
    logic [1:0] cv_range_reg;

    // Sequencer.
    state_t state_reg, state_next;
    ctrl_t  ctrl;

    // Latched channel word.
    logic [2:0]         ch_reg;
    logic               grp_reg;
    logic signed [15:0] audio_reg;
    logic               aconn_reg;
    logic signed [15:0] knob_reg;
    logic               cv_neg_reg;

    // Gain and product.
    logic               gain_neg_reg;
    logic [ENTRY_W-1:0] gain_mag_reg;
    logic [MCAND_W-1:0] y_mag_reg;

    // Group state.
    logic signed [17:0] group0_sum_reg;
    logic signed [19:0] group1_sum_reg;
    logic signed [17:0] hole_value_reg;

    // Output register.
    logic               out_valid_reg;
    logic [2:0]         out_channel_reg;
    logic signed [17:0] channel_out_reg;
    logic               mix_valid_reg;
    logic signed [15:0] mix_out_reg;

    // Unit connections.
    logic                  grp_in;
    logic [15:0]           cv_mag;
    logic [DIVIDEND_W-1:0] cv_scaled;
    logic [DIVIDEND_W-1:0] dividend;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;
    logic [MCAND_W-1:0]    mul_mcand;
    logic [MUL_BITS-1:0]   mul_mplier;
    logic                  mul_done;
    logic [MRES_W-1:0]     mul_res;
    logic [ENTRY_W-1:0]    rom_lo;
    logic [ENTRY_W-1:0]    rom_diff;
    logic [FRAC_W-1:0]     rom_frac;

    logic signed [17:0] cv_term;
    logic signed [17:0] gain_sum;
    logic signed [17:0] gain_clamped;
    logic signed [17:0] src;
    logic [MCAND_W-1:0] src_mag;
    logic signed [18:0] y;
    logic               is_g0_last;
    logic               is_g1_first;
    logic               is_g1_last;
    logic signed [19:0] s0;
    logic signed [17:0] s0_sat;
    logic signed [20:0] s1;
    logic signed [19:0] s1_sat;
    logic signed [19:0] mix_sel;
    logic signed [15:0] mix_sat;
    logic               out_free;
    logic               curve_en;

    // Configuration write port.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_mode_reg <= 2'd0;
            wormhole_reg <= 1'b1;
            cv_range_reg <= 2'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EXP_MODE: exp_mode_reg <= cfg_data;
                CFG_WORMHOLE: wormhole_reg <= cfg_data[0];
                CFG_CV_RANGE: cv_range_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Divider operand: |CV| scaled by 4 or 8, plus two for rounding of the divide by five.
    assign grp_in    = ({2'b00, channel} >= G1_FIRST);
    assign cv_mag    = cv_sample[15] ? 16'(-cv_sample) : 16'(cv_sample);
    assign cv_scaled = cv_range_reg[grp_in] ? {1'b0, cv_mag, 2'b00} : {cv_mag, 3'b000};
    assign dividend  = cv_connected ? cv_scaled + DIVIDEND_W'(2) : '0;

    dqvm_div5 u_div5 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (dividend),
        .done     (div_done),
        .quotient (div_quot)
    );

    dqvm_exp_rom #(
        .EXP_TABLE_POINTS (EXP_TABLE_POINTS)
    ) u_exp_rom (
        .clk  (clk),
        .load (ctrl.rom_load),
        .mag  (gain_mag_reg),
        .lo   (rom_lo),
        .diff (rom_diff),
        .frac (rom_frac)
    );

    // The multiplier serves both the curve interpolation and gain times input.
    assign mul_mcand  = ctrl.mul_sel_curve ? MCAND_W'(rom_diff) : src_mag;
    assign mul_mplier = ctrl.mul_sel_curve ? MUL_BITS'(rom_frac) : gain_mag_reg;

    dqvm_smul u_smul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .done   (mul_done),
        .result (mul_res)
    );

    // Gain: knob plus signed CV term, clamped to plus or minus one.
    assign cv_term  = cv_neg_reg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    assign gain_sum = $signed({{2{knob_reg[15]}}, knob_reg}) + cv_term;

    always_comb
    begin
        if (gain_sum > GAIN_MAX)
        begin
            gain_clamped = GAIN_MAX;
        end
        else if (gain_sum < GAIN_MIN)
        begin
            gain_clamped = GAIN_MIN;
        end
        else
        begin
            gain_clamped = gain_sum;
        end
    end

    assign curve_en = exp_mode_reg[grp_reg];

    // Source: the jack, else the wormhole value in group 1 when enabled, else 10 V.
    always_comb
    begin
        if (aconn_reg)
        begin
            src = 18'(audio_reg);
        end
        else if (grp_reg && wormhole_reg)
        begin
            src = hole_value_reg;
        end
        else
        begin
            src = TEN_VOLTS;
        end
    end

    assign src_mag = src[17] ? MCAND_W'(-src) : MCAND_W'(src);

    // Signed channel result and the saturating group sums.
    assign y = (gain_neg_reg ^ src[17]) ? -$signed({1'b0, y_mag_reg})
                                        : $signed({1'b0, y_mag_reg});

    assign is_g0_last  = ({2'b00, ch_reg} == G0_LAST);
    assign is_g1_first = ({2'b00, ch_reg} == G1_FIRST);
    assign is_g1_last  = ({2'b00, ch_reg} == G1_LAST);

    assign s0 = ((ch_reg == 3'd0) ? 20'sd0 : 20'(group0_sum_reg)) + 20'(y);
    assign s1 = (is_g1_first ? 21'sd0 : 21'(group1_sum_reg)) + 21'(y);

    always_comb
    begin
        if (s0 > SUM0_MAX)
        begin
            s0_sat = 18'(SUM0_MAX);
        end
        else if (s0 < SUM0_MIN)
        begin
            s0_sat = 18'(SUM0_MIN);
        end
        else
        begin
            s0_sat = s0[17:0];
        end
        if (s1 > SUM1_MAX)
        begin
            s1_sat = 20'(SUM1_MAX);
        end
        else if (s1 < SUM1_MIN)
        begin
            s1_sat = 20'(SUM1_MIN);
        end
        else
        begin
            s1_sat = s1[19:0];
        end
    end

    // Mix output clamped to plus or minus 10 V.
    assign mix_sel = grp_reg ? s1_sat : 20'(s0_sat);

    always_comb
    begin
        if (mix_sel > MIX_MAX)
        begin
            mix_sat = 16'(MIX_MAX);
        end
        else if (mix_sel < MIX_MIN)
        begin
            mix_sat = 16'(MIX_MIN);
        end
        else
        begin
            mix_sat = mix_sel[15:0];
        end
    end

    assign out_free = !(out_valid_reg && out_stall);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DIV;
            ST_DIV:      if (div_done) state_next = ST_GAIN;
            ST_GAIN:     state_next = curve_en ? ST_CRV_IDX : ST_MUL_GO;
            ST_CRV_IDX:  state_next = ST_CRV_RD;
            ST_CRV_RD:   state_next = ST_CRV_GO;
            ST_CRV_GO:   state_next = ST_CRV_WAIT;
            ST_CRV_WAIT: if (mul_done) state_next = ST_MUL_GO;
            ST_MUL_GO:   state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: if (mul_done) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control word for the current state.
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.accept    = in_valid;
                ctrl.div_start = in_valid;
            end
            ST_GAIN:     ctrl.gain_load = 1'b1;
            ST_CRV_IDX:  ctrl.rom_load = 1'b1;
            ST_CRV_GO:
            begin
                ctrl.mul_start     = 1'b1;
                ctrl.mul_sel_curve = 1'b1;
            end
            ST_CRV_WAIT: ctrl.curve_take = mul_done;
            ST_MUL_GO:   ctrl.mul_start = 1'b1;
            ST_MUL_WAIT: ctrl.prod_take = mul_done;
            ST_DONE:     ctrl.out_load = out_free;
            default:     ;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Channel word, gain and product registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            ch_reg     <= channel;
            grp_reg    <= grp_in;
            audio_reg  <= audio_sample;
            aconn_reg  <= audio_connected;
            knob_reg   <= level_knob;
            cv_neg_reg <= cv_sample[15];
        end
        if (ctrl.gain_load)
        begin
            gain_neg_reg <= gain_clamped[17];
            gain_mag_reg <= gain_clamped[17] ? ENTRY_W'(-gain_clamped)
                                             : ENTRY_W'(gain_clamped);
        end
        else if (ctrl.curve_take)
        begin
            gain_mag_reg <= rom_lo + mul_res[ENTRY_W-1:0];
        end
        if (ctrl.prod_take)
        begin
            y_mag_reg <= mul_res[MCAND_W-1:0];
        end
    end

    // Group sums and wormhole value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group0_sum_reg <= '0;
            group1_sum_reg <= '0;
            hole_value_reg <= '0;
        end
        else if (ctrl.out_load)
        begin
            if (!grp_reg)
            begin
                group0_sum_reg <= s0_sat;
                if (is_g0_last)
                begin
                    hole_value_reg <= s0_sat;
                end
            end
            else
            begin
                group1_sum_reg <= s1_sat;
            end
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: result word.
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_channel_reg <= ch_reg;
            channel_out_reg <= y[17:0];
            mix_valid_reg   <= grp_reg ? is_g1_last : is_g0_last;
            mix_out_reg     <= (grp_reg ? is_g1_last : is_g0_last) ? mix_sat : 16'sd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign channel_out = channel_out_reg;
    assign mix_valid   = mix_valid_reg;
    assign mix_out     = mix_out_reg;

    // A result word appears only out of the final sequencer state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result word appeared outside the final state");

    // The group sum is only flagged on a group's last channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mix_valid) |->
            ({2'b00, out_channel} == G0_LAST || {2'b00, out_channel} == G1_LAST))
        else $error("mix flagged on a channel that does not end a group");

    // Without a group sum the mix output reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !mix_valid) |-> (mix_out == 16'sd0))
        else $error("mix output nonzero without a group sum");

endmodule

### rtl/core/dqvm_div5.sv
// Bit-serial restoring divider by five, one quotient bit per cycle.
module dqvm_div5 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [dqvm_pkg::DIVIDEND_W-1:0] dividend,
    output logic                            done,
    output logic [dqvm_pkg::QUOT_W-1:0]     quotient
);
    import dqvm_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [3:0] DIVISOR = 4'd5;

    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [2:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [3:0]            trial;
    logic [3:0]            trial_diff;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb
    begin
        trial      = {rem_reg, num_reg[DIVIDEND_W-1]};
        trial_diff = trial - DIVISOR;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start)
        begin
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            cnt_next = CNT_W'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            num_next = {num_reg[DIVIDEND_W-2:0], 1'b0};
            if (trial >= DIVISOR)
            begin
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
                rem_next = trial_diff[2:0];
            end
            else
            begin
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
                rem_next = trial[2:0];
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Step counter and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Dividend, partial remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // The quotient of the largest dividend the core forms, 8 * 32768 + 2, by five fits in 16 bits.
    assign done     = done_reg;
    assign quotient = quo_reg[QUOT_W-1:0];

endmodule

### rtl/core/dqvm_smul.sv
// Bit-serial shift-and-add multiplier with a final round-half-up shift by 14 bits.
module dqvm_smul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dqvm_pkg::MCAND_W-1:0]  mcand,
    input  logic [dqvm_pkg::MUL_BITS-1:0] mplier,
    output logic                          done,
    output logic [dqvm_pkg::MRES_W-1:0]   result
);
    import dqvm_pkg::*;

    localparam int CNT_W = $clog2(MUL_BITS + 2);
    localparam logic [PROD_W:0] HALF_LSB = (PROD_W + 1)'(1) << (FRAC_W - 1);

    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [MCAND_W-1:0]  mcand_reg, mcand_next;
    logic [MUL_BITS-1:0] bits_reg, bits_next;
    logic [MRES_W-1:0]   res_reg, res_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [PROD_W:0]     rounded;

    // Multiplier bits are consumed most significant first; the last count rounds.
    always_comb
    begin
        rounded    = {1'b0, acc_reg} + HALF_LSB;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        bits_next  = bits_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start)
        begin
            acc_next   = '0;
            mcand_next = mcand;
            bits_next  = mplier;
            cnt_next   = CNT_W'(MUL_BITS + 1);
        end
        else if (cnt_reg > CNT_W'(1))
        begin
            acc_next  = {acc_reg[PROD_W-2:0], 1'b0}
                        + (bits_reg[MUL_BITS-1] ? PROD_W'(mcand_reg) : '0);
            bits_next = {bits_reg[MUL_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            res_next  = rounded[PROD_W-1:FRAC_W];
            cnt_next  = '0;
            done_next = 1'b1;
        end
    end

    // Step counter and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Accumulator and operand shift registers.
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        bits_reg  <= bits_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### rtl/core/dqvm_exp_rom.sv
// Exponential gain curve table, built at elaboration, with a registered two-entry read.
module dqvm_exp_rom #(
    parameter int EXP_TABLE_POINTS = dqvm_pkg::EXP_POINTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [dqvm_pkg::ENTRY_W-1:0] mag,
    output logic [dqvm_pkg::ENTRY_W-1:0] lo,
    output logic [dqvm_pkg::ENTRY_W-1:0] diff,
    output logic [dqvm_pkg::FRAC_W-1:0]  frac
);
    import dqvm_pkg::*;

    localparam int IDX_W = $clog2(EXP_TABLE_POINTS + 1);
    localparam int POS_W = ENTRY_W + IDX_W;
    localparam int TAB_W = (EXP_TABLE_POINTS + 1) * ENTRY_W;
    localparam longint unsigned LOG2_50_Q30 = 64'd6060044440;
    localparam longint unsigned HALF_POINTS = EXP_TABLE_POINTS / 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EXP_TABLE_POINTS);

    // Integer square root, one result bit per pass.
    function automatic longint unsigned isqrt(input longint unsigned val);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        int              k;
        v = val;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        for (k = 0; k < 32; k++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unsigned shift-and-subtract division for the table build.
    function automatic longint unsigned long_div(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        int              k;
        q   = 0;
        rem = 0;
        for (k = 63; k >= 0; k--)
        begin
            rem = (rem << 1) | ((num >> k) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                q   = q | (64'd1 << k);
            end
        end
        return q;
    endfunction

    // Entry i is round(16384*(50^(i/N)-1)/49), evaluated in base 2 with Q30 roots
    // of two, clipped at one and kept non-decreasing.
    function automatic logic [TAB_W-1:0] build_exp_tab();
        logic [TAB_W-1:0] tab;
        longint unsigned  root [0:30];
        longint unsigned  y;
        longint unsigned  r;
        longint unsigned  v;
        longint unsigned  e;
        longint unsigned  t;
        longint unsigned  prev;
        int               i;
        int               k;
        tab     = '0;
        root[0] = 64'd1 << 31;
        for (k = 1; k <= 30; k++)
        begin
            root[k] = isqrt(root[k-1] << 30);
        end
        prev = 0;
        for (i = 0; i <= EXP_TABLE_POINTS; i++)
        begin
            y = long_div(longint'(i) * LOG2_50_Q30 + HALF_POINTS, 64'(EXP_TABLE_POINTS));
            r = 64'd1 << 30;
            for (k = 1; k <= 30; k++)
            begin
                if (((y >> (30 - k)) & 64'd1) != 0)
                begin
                    r = (r * root[k] + (64'd1 << 29)) >> 30;
                end
            end
            v = r << (y >> 30);
            e = long_div((v - (64'd1 << 30)) * ONE_Q14 + (64'd49 << 29), 64'd49 << 30);
            t = (e > ONE_Q14) ? ONE_Q14 : e;
            if (i > 0 && t < prev)
            begin
                t = prev;
            end
            if (i == 0)
            begin
                t = 0;
            end
            if (i == EXP_TABLE_POINTS)
            begin
                t = ONE_Q14;
            end
            prev = t;
            tab[i*ENTRY_W +: ENTRY_W] = t[ENTRY_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [TAB_W-1:0] EXP_TAB = build_exp_tab();

    logic [POS_W-1:0]   pos;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_hi;
    logic [FRAC_W-1:0]  frac_reg;
    logic [ENTRY_W-1:0] lo_reg;
    logic [ENTRY_W-1:0] hi_reg;

    // Segment index and fraction of |gain| * N.
    assign pos    = POS_W'(mag) * POS_W'(EXP_TABLE_POINTS);
    assign idx_hi = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg  <= pos[FRAC_W +: IDX_W];
            frac_reg <= pos[FRAC_W-1:0];
        end
    end

    // Registered read of both segment ends.
    always_ff @(posedge clk)
    begin
        lo_reg <= EXP_TAB[idx_reg*ENTRY_W +: ENTRY_W];
        hi_reg <= EXP_TAB[idx_hi*ENTRY_W +: ENTRY_W];
    end

    assign lo   = lo_reg;
    assign diff = hi_reg - lo_reg;
    assign frac = frac_reg;

endmodule

### sim/dual_quad_vca_mixer_core_test.sv
// Self-checking testbench for the dual quad VCA mixer core.
module dual_quad_vca_mixer_core_test;
    import dqvm_pkg::*;

    localparam int CURVE_POINTS = EXP_POINTS_DEFAULT;
    localparam longint unsigned LOG2_50_Q30 = 64'd6060044440;
    localparam longint TEN_VOLTS = 20480;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 80;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic [2:0]         ch;
        logic signed [15:0] audio;
        logic               audio_conn;
        logic signed [15:0] knob;
        logic signed [15:0] cv;
        logic               cv_conn;
    } vca_word_t;

    typedef struct {
        logic [2:0]         ch;
        logic signed [17:0] level;
        logic               mix_valid;
        logic signed [15:0] mix;
    } vca_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         channel = '0;
    logic signed [15:0] audio_sample = '0;
    logic               audio_connected = 1'b0;
    logic signed [15:0] level_knob = '0;
    logic signed [15:0] cv_sample = '0;
    logic               cv_connected = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         out_channel;
    logic signed [17:0] channel_out;
    logic               mix_valid;
    logic signed [15:0] mix_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [1:0]         cfg_data = '0;

    // Predictor state: configuration copy, group sums and the wormhole level.
    logic [1:0]      curve_on = 2'b00;
    logic            wormhole_en = 1'b1;
    logic [1:0]      cv_tenth = 2'b11;
    longint          grp0_acc = 0;
    longint          grp1_acc = 0;
    longint          wormhole_level = 0;
    longint unsigned half_roots [0:30];
    longint          bend_tab [0:CURVE_POINTS];

    vca_result_t vca_results_due [$];
    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  idling_on = 1'b1;
    bit  long_hold_pending = 1'b0;

    dual_quad_vca_mixer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .channel         (channel),
        .audio_sample    (audio_sample),
        .audio_connected (audio_connected),
        .level_knob      (level_knob),
        .cv_sample       (cv_sample),
        .cv_connected    (cv_connected),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_channel     (out_channel),
        .channel_out     (channel_out),
        .mix_valid       (mix_valid),
        .mix_out         (mix_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Rounded division, halves away from zero.
    function automatic longint div_round(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // 2^f for a Q30 fraction f, built from successive square roots of two.
    function automatic longint unsigned pow2_frac(longint unsigned f);
        longint unsigned r;
        r = 64'd1 << 30;
        for (int k = 1; k <= 30; k++)
            if (f[30 - k])
                r = (r * half_roots[k] + (64'd1 << 29)) >> 30;
        return r;
    endfunction

    // Gain curve (50^x - 1) / 49 sampled at CURVE_POINTS + 1 points, Q1.14.
    function automatic void build_bend_table();
        longint unsigned y;
        longint unsigned v;
        longint unsigned e;
        longint unsigned t;
        half_roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 30; k++)
            half_roots[k] = int_sqrt(half_roots[k - 1] << 30);
        for (int i = 0; i <= CURVE_POINTS; i++)
        begin
            y = (LOG2_50_Q30 * i + CURVE_POINTS / 2) / CURVE_POINTS;
            v = pow2_frac(y & ((64'd1 << 30) - 1)) << (y >> 30);
            e = ((v - (64'd1 << 30)) * ONE_Q14 + (64'd49 << 29)) / (64'd49 << 30);
            t = (e > ONE_Q14) ? ONE_Q14 : e;
            if (i > 0 && t < bend_tab[i - 1])
                t = bend_tab[i - 1];
            bend_tab[i] = t;
        end
        bend_tab[0] = 0;
        bend_tab[CURVE_POINTS] = ONE_Q14;
    endfunction

    // Interpolated lookup on the magnitude; the sign is put back afterwards.
    function automatic longint bend_gain(longint g);
        longint mag;
        longint pos;
        longint idx;
        longint fr;
        longint e;
        mag = (g < 0) ? -g : g;
        pos = mag * CURVE_POINTS;
        idx = pos >> FRAC_W;
        fr = pos & (ONE_Q14 - 1);
        if (idx >= CURVE_POINTS)
            e = bend_tab[CURVE_POINTS];
        else
            e = bend_tab[idx] + (((bend_tab[idx + 1] - bend_tab[idx]) * fr + 8192) >> FRAC_W);
        return (g < 0) ? -e : e;
    endfunction

    // Expected result of one channel word; advances the group sums.
    function automatic vca_result_t amplify_and_mix(vca_word_t w);
        vca_result_t r;
        int     grp;
        int     first_ch;
        int     last_ch;
        longint src;
        longint cv_term;
        longint gain;
        longint y;
        longint mixed;
        grp = (int'(w.ch) < CHANNELS_PER_GROUP) ? 0 : 1;
        first_ch = grp * CHANNELS_PER_GROUP;
        last_ch = first_ch + CHANNELS_PER_GROUP - 1;
        if (w.audio_conn)
            src = w.audio;
        else if (grp == 1 && wormhole_en)
            src = wormhole_level;
        else
            src = TEN_VOLTS;
        cv_term = 0;
        if (w.cv_conn)
            cv_term = div_round(longint'(w.cv) * (cv_tenth[grp] ? 4 : 8), 5);
        gain = clip(longint'(w.knob) + cv_term, -ONE_Q14, ONE_Q14);
        if (curve_on[grp])
            gain = bend_gain(gain);
        y = div_round(gain * src, ONE_Q14);
        r.ch = w.ch;
        r.level = 18'(y);
        r.mix_valid = 1'b0;
        r.mix = '0;
        mixed = 0;
        if (grp == 0)
        begin
            grp0_acc = clip((int'(w.ch) == first_ch) ? y : grp0_acc + y, -131072, 131071);
            if (int'(w.ch) == last_ch)
            begin
                r.mix_valid = 1'b1;
                mixed = grp0_acc;
                wormhole_level = grp0_acc;
            end
        end
        else
        begin
            grp1_acc = clip((int'(w.ch) == first_ch) ? y : grp1_acc + y, -524288, 524287);
            if (int'(w.ch) == last_ch)
            begin
                r.mix_valid = 1'b1;
                mixed = grp1_acc;
            end
        end
        if (r.mix_valid)
            r.mix = 16'(clip(mixed, -TEN_VOLTS, TEN_VOLTS));
        return r;
    endfunction

    function automatic vca_word_t make_word(logic [2:0] ch, int audio, bit audio_conn,
                                            int knob, int cv, bit cv_conn);
        vca_word_t w;
        w.ch = ch;
        w.audio = 16'(audio);
        w.audio_conn = audio_conn;
        w.knob = 16'(knob);
        w.cv = 16'(cv);
        w.cv_conn = cv_conn;
        return w;
    endfunction

    // Mostly in range, now and then an extreme or a raw 16-bit pattern.
    function automatic logic [15:0] pick_value(int limit);
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'(limit);
            2: return 16'(-limit);
            default: return 16'(int'($urandom_range(0, 2 * limit)) - limit);
        endcase
    endfunction

    function automatic vca_word_t random_word(logic [2:0] ch);
        vca_word_t w;
        w.ch = ch;
        w.audio = pick_value(20480);
        w.audio_conn = ($urandom_range(0, 3) != 0);
        w.knob = pick_value(ONE_Q14);
        w.cv = pick_value(20480);
        w.cv_conn = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Offer one word, with an occasional gap before it, and wait for it to be taken.
    task automatic send_word(vca_word_t w);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        channel <= w.ch;
        audio_sample <= w.audio;
        audio_connected <= w.audio_conn;
        level_knob <= w.knob;
        cv_sample <= w.cv;
        cv_connected <= w.cv_conn;
        do
            @(posedge clk);
        while (in_stall);
        vca_results_due.push_back(amplify_and_mix(w));
    endtask

    // Stop offering words and wait until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (vca_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EXP_MODE: curve_on = data;
            CFG_WORMHOLE: wormhole_en = data[0];
            CFG_CV_RANGE: cv_tenth = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Well-formed frames of channels 0 to 7, with some stray words mixed in.
    task automatic run_frames(int frames);
        repeat (frames)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 5))
                    send_word(random_word(3'($urandom)));
            end
            else
            begin
                for (int c = 0; c < 2 * CHANNELS_PER_GROUP; c++)
                    send_word(random_word(3'(c)));
            end
        end
    endtask

    // Reset configuration: empty wormhole, saturation of both sums, unconnected jacks.
    task automatic test_reset_defaults();
        // Group 1 before group 0 has ended: the wormhole level is still zero.
        send_word(make_word(3'd4, 0, 0, 16384, 0, 0));
        send_word(make_word(3'd5, 20480, 1, -16384, 0, 0));
        send_word(make_word(3'd6, -20480, 1, 0, 20480, 1));
        send_word(make_word(3'd7, 12345, 1, 16384, -20480, 1));
        // Full-scale negative inputs drive the group 0 sum into saturation.
        send_word(make_word(3'd0, -32768, 1, -32768, 0, 0));
        send_word(make_word(3'd1, -32768, 1, -16384, 0, 0));
        send_word(make_word(3'd2, -32768, 1, -16384, 32767, 0));
        send_word(make_word(3'd3, -32768, 1, 0, -32768, 1));
        // Wormhole fed group 1, with a repeated channel, saturates the wider sum.
        send_word(make_word(3'd4, 0, 0, 16384, 0, 0));
        send_word(make_word(3'd5, 0, 0, 16384, 0, 0));
        send_word(make_word(3'd6, 0, 0, 16384, 0, 0));
        send_word(make_word(3'd6, 0, 0, 16384, 0, 0));
        send_word(make_word(3'd7, 0, 0, 16384, 0, 0));
        // Unconnected group 0 inputs read as ten volts.
        send_word(make_word(3'd0, 0, 0, 32767, 0, 0));
        send_word(make_word(3'd1, 32767, 1, 16384, 0, 0));
        send_word(make_word(3'd2, 0, 0, -1, 0, 0));
        send_word(make_word(3'd3, 0, 0, 8193, 1, 1));
    endtask

    // Exponential curve on both groups with the 0.2 per volt CV scale.
    task automatic test_curve_shape();
        drain();
        write_reg(CFG_EXP_MODE, 2'b11);
        write_reg(CFG_CV_RANGE, 2'b00);
        send_word(make_word(3'd0, 20480, 1, 0, 0, 0));
        send_word(make_word(3'd1, 20480, 1, 16384, 0, 0));
        send_word(make_word(3'd2, 20480, 1, -16384, 0, 0));
        send_word(make_word(3'd3, 20480, 1, 256, 0, 0));
        send_word(make_word(3'd4, 20480, 1, -8191, 0, 0));
        send_word(make_word(3'd5, 20480, 1, 0, 10240, 1));
        send_word(make_word(3'd6, -20480, 1, 16383, 0, 0));
        send_word(make_word(3'd7, 20480, 1, 0, -5121, 1));
    endtask

    // Random frames under a series of register settings, the extremes among them.
    task automatic test_register_sweep();
        logic [1:0] curve_set [6] = '{2'b00, 2'b11, 2'b01, 2'b10, 2'b11, 2'b00};
        logic       hole_set [6]  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        logic [1:0] scale_set [6] = '{2'b11, 2'b00, 2'b10, 2'b01, 2'b11, 2'b00};
        for (int k = 0; k < 6; k++)
        begin
            drain();
            write_reg(CFG_EXP_MODE, curve_set[k]);
            write_reg(CFG_WORMHOLE, {1'($urandom), hole_set[k]});
            write_reg(CFG_CV_RANGE, scale_set[k]);
            if (k == 2)
                write_reg(CFG_SPARE, 2'b11);
            run_frames(18);
        end
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        drain();
        write_reg(CFG_EXP_MODE, 2'b01);
        write_reg(CFG_WORMHOLE, 2'b01);
        long_hold_pending = 1'b1;
        run_frames(2);
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        drain();
        write_reg(CFG_EXP_MODE, 2'b10);
        write_reg(CFG_CV_RANGE, 2'b01);
        idling_on = 1'b0;
        run_frames(12);
    endtask

    // Receiver stall: one long hold-off on request, otherwise short random bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        vca_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (vca_results_due.size() == 0)
                report_mismatch($sformatf("result word for channel %0d with none expected",
                                          out_channel));
            else
            begin
                want = vca_results_due.pop_front();
                if (out_channel !== want.ch)
                    report_mismatch($sformatf("out_channel %0d, expected %0d",
                                              out_channel, want.ch));
                if (channel_out !== want.level)
                    report_mismatch($sformatf("ch %0d channel_out %0d, expected %0d",
                                              want.ch, channel_out, want.level));
                if (mix_valid !== want.mix_valid)
                    report_mismatch($sformatf("ch %0d mix_valid %0b, expected %0b",
                                              want.ch, mix_valid, want.mix_valid));
                if (mix_out !== want.mix)
                    report_mismatch($sformatf("ch %0d mix_out %0d, expected %0d",
                                              want.ch, mix_out, want.mix));
            end
        end
    end

    // Watchdog: too long without any word moving on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        build_bend_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_curve_shape();
        test_register_sweep();
        test_backpressure();
        test_steady_stream();
        in_valid <= 1'b0;
        while (vca_results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### dual_quad_vca_mixer_core.f
rtl/core/dqvm_pkg.sv
rtl/core/dqvm_div5.sv
rtl/core/dqvm_smul.sv
rtl/core/dqvm_exp_rom.sv
rtl/core/dual_quad_vca_mixer_core.sv
sim/dual_quad_vca_mixer_core_test.sv
